// ===== src/srw_pkg.sv =====
// ----------------------------------------------------------------------------
// srw_pkg
// Shared types and constants of the sequence reorder window.
// ----------------------------------------------------------------------------
package srw_pkg;

   localparam int SESSIONS = 16;
   localparam int WINDOW   = 32;
   localparam int SESS_W   = 4;
   localparam int WIN_W    = $clog2(WINDOW);
   localparam int SLOT_W   = SESS_W + WIN_W;
   localparam int SLOTS    = SESSIONS * WINDOW;
   localparam int SEQ_W    = 16;
   localparam int DISP_W   = 3;

   localparam logic CMD_DELIVER = 1'b0;
   localparam logic CMD_CLEAR   = 1'b1;

   typedef enum logic [DISP_W-1:0] {
      DISP_RELEASED  = 3'd0,
      DISP_DUPLICATE = 3'd1,
      DISP_STORED    = 3'd2,
      DISP_COLLISION = 3'd3,
      DISP_EMPTY     = 3'd4,
      DISP_CLEARED   = 3'd5
   } disp_type;

   typedef struct packed {
      logic [SEQ_W-1:0] seq;
      logic [SEQ_W-1:0] handle;
      logic [SEQ_W-1:0] length;
   } slot_entry_type;

   typedef struct packed {
      logic [SEQ_W-1:0] a;
      logic [SEQ_W-1:0] b;
   } cmp_req_type;

   typedef struct packed {
      logic             lt;
      logic             eq;
      logic [SEQ_W-1:0] b_next;
   } cmp_rsp_type;

endpackage

// ===== src/sequence_reorder_window.sv =====
// ----------------------------------------------------------------------------
// sequence_reorder_window
// Per-session reorder window releasing packet handles in sequence order.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction: a deliver or clear command for a session.
//   rsp_* returns one or more results per transaction; rsp_last marks the
//   final one. Both channels use valid/stall; a transaction moves when valid
//   is high and stall is low.
//   Timing: the block takes one request at a time; req_stall is high from
//   acceptance until the session is written back. A request passes session
//   lookup, classification and write-back; an in-order release also runs the
//   drain loop between classification and write-back, one slot RAM read plus
//   one compare per stored entry. A drain that ends on an entry from a later
//   lap also reads and compares that entry.
//   A stalled receiver holds the result register and the sequencer waits.
//   Reset: synchronous; all expected numbers become zero and every session
//   window reads empty at once (per-session row valid bits), so no clearing
//   pass is needed. Slot payload storage is not cleared.
// ----------------------------------------------------------------------------
module sequence_reorder_window import srw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_command,
   input  logic [SESS_W-1:0] req_session_slot,
   input  logic [SEQ_W-1:0]  req_seq_number,
   input  logic [SEQ_W-1:0]  req_payload_handle,
   input  logic [SEQ_W-1:0]  req_payload_length,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DISP_W-1:0] rsp_disposition,
   output logic [SEQ_W-1:0]  rsp_out_handle,
   output logic [SEQ_W-1:0]  rsp_out_length,
   output logic [SEQ_W-1:0]  rsp_out_seq,
   output logic              rsp_last
);

   cmp_req_type       cmp_req;
   cmp_rsp_type       cmp_rsp;
   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_wr_addr;
   slot_entry_type    ram_wr_data;
   logic              ram_rd_en;
   logic [SLOT_W-1:0] ram_rd_addr;
   slot_entry_type    ram_rd_data;

   srw_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_session_slot   (req_session_slot),
      .req_seq_number     (req_seq_number),
      .req_payload_handle (req_payload_handle),
      .req_payload_length (req_payload_length),
      .cmp_req            (cmp_req),
      .cmp_rsp            (cmp_rsp),
      .ram_wr_en          (ram_wr_en),
      .ram_wr_addr        (ram_wr_addr),
      .ram_wr_data        (ram_wr_data),
      .ram_rd_en          (ram_rd_en),
      .ram_rd_addr        (ram_rd_addr),
      .ram_rd_data        (ram_rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_disposition    (rsp_disposition),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_out_length     (rsp_out_length),
      .rsp_out_seq        (rsp_out_seq),
      .rsp_last           (rsp_last)
   );

   srw_cmp_unit u_cmp (
      .cmp_req (cmp_req),
      .cmp_rsp (cmp_rsp)
   );

   srw_slot_ram #(
      .DEPTH (SLOTS),
      .WIDTH ($bits(slot_entry_type))
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== src/srw_slot_ram.sv =====
// ----------------------------------------------------------------------------
// srw_slot_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module srw_slot_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/srw_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// srw_cmp_unit
// Shared 16-bit sequence compare and increment unit.
// ----------------------------------------------------------------------------
module srw_cmp_unit import srw_pkg::*; (
   input  cmp_req_type cmp_req,
   output cmp_rsp_type cmp_rsp
);

   assign cmp_rsp.lt     = cmp_req.a < cmp_req.b;
   assign cmp_rsp.eq     = cmp_req.a == cmp_req.b;
   assign cmp_rsp.b_next = cmp_req.b + SEQ_W'(1);

endmodule

// ===== src/srw_ctrl.sv =====
// ----------------------------------------------------------------------------
// srw_ctrl
// Sequencer: session lookup, classify, store, and in-order drain.
// ----------------------------------------------------------------------------
module srw_ctrl import srw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [SESS_W-1:0]     req_session_slot,
   input  logic [SEQ_W-1:0]      req_seq_number,
   input  logic [SEQ_W-1:0]      req_payload_handle,
   input  logic [SEQ_W-1:0]      req_payload_length,
   output cmp_req_type           cmp_req,
   input  cmp_rsp_type           cmp_rsp,
   output logic                  ram_wr_en,
   output logic [SLOT_W-1:0]     ram_wr_addr,
   output slot_entry_type        ram_wr_data,
   output logic                  ram_rd_en,
   output logic [SLOT_W-1:0]     ram_rd_addr,
   input  slot_entry_type        ram_rd_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DISP_W-1:0]     rsp_disposition,
   output logic [SEQ_W-1:0]      rsp_out_handle,
   output logic [SEQ_W-1:0]      rsp_out_length,
   output logic [SEQ_W-1:0]      rsp_out_seq,
   output logic                  rsp_last
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_DECIDE,
      S_DRAIN_RD,
      S_DRAIN_CHK,
      S_DONE
   } state_type;

   state_type         state_ff;
   logic              cmd_ff;
   logic [SESS_W-1:0] sess_ff;
   logic [SEQ_W-1:0]  seq_ff;
   logic [SEQ_W-1:0]  handle_ff;
   logic [SEQ_W-1:0]  length_ff;
   logic [SEQ_W-1:0]  expw_ff;
   logic [WINDOW-1:0] mask_ff;
   slot_entry_type    pend_ff;
   logic [SESSIONS-1:0] row_valid_ff;
   logic [SEQ_W-1:0]  exp_mem_ff [SESSIONS];

   // occupancy mask per session; rows are valid once written
   logic [WINDOW-1:0] mask_mem [SESSIONS];
   logic [WINDOW-1:0] mask_q_ff;

   logic              rsp_valid_ff;
   disp_type          rsp_disp_ff;
   slot_entry_type    rsp_entry_ff;
   logic              rsp_last_ff;

   logic              accept;
   logic              out_free;
   logic [WIN_W-1:0]  seq_idx;
   logic [WIN_W-1:0]  exp_idx;
   logic              is_clear;
   logic              is_empty;
   logic              is_dup;
   logic              is_coll;
   logic              is_store;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign seq_idx   = seq_ff[WIN_W-1:0];
   assign exp_idx   = expw_ff[WIN_W-1:0];

   assign cmp_req.a = (state_ff == S_DRAIN_CHK) ? ram_rd_data.seq : seq_ff;
   assign cmp_req.b = expw_ff;

   // classification of the transaction in S_DECIDE
   assign is_clear = (cmd_ff == CMD_CLEAR);
   assign is_empty = !is_clear && (length_ff == '0);
   assign is_dup   = !is_clear && !is_empty && cmp_rsp.lt;
   assign is_coll  = !is_clear && !is_empty && !cmp_rsp.lt && !cmp_rsp.eq && mask_ff[seq_idx];
   assign is_store = !is_clear && !is_empty && !cmp_rsp.lt && !cmp_rsp.eq && !mask_ff[seq_idx];

   assign ram_wr_en   = (state_ff == S_DECIDE) && out_free && is_store;
   assign ram_wr_addr = {sess_ff, seq_idx};
   assign ram_wr_data = '{seq: seq_ff, handle: handle_ff, length: length_ff};
   assign ram_rd_en   = (state_ff == S_DRAIN_RD) && mask_ff[exp_idx];
   assign ram_rd_addr = {sess_ff, exp_idx};

   always_ff @(posedge clock) begin
      if (accept) begin
         mask_q_ff <= mask_mem[req_session_slot];
      end
      if (state_ff == S_DONE) begin
         mask_mem[sess_ff] <= mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
         for (int i = 0; i < SESSIONS; i++) begin
            exp_mem_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cmd_ff    <= req_command;
                  sess_ff   <= req_session_slot;
                  seq_ff    <= req_seq_number;
                  handle_ff <= req_payload_handle;
                  length_ff <= req_payload_length;
                  state_ff  <= S_LOAD;
               end
            end
            S_LOAD: begin
               mask_ff  <= row_valid_ff[sess_ff] ? mask_q_ff : '0;
               expw_ff  <= exp_mem_ff[sess_ff];
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (out_free) begin
                  rsp_entry_ff <= '0;
                  rsp_last_ff  <= 1'b1;
                  priority if (is_clear) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_disp_ff  <= DISP_CLEARED;
                     mask_ff      <= '0;
                     expw_ff      <= '0;
                     state_ff     <= S_DONE;
                  end else if (is_empty) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_disp_ff  <= DISP_EMPTY;
                     state_ff     <= S_DONE;
                  end else if (is_dup) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_disp_ff  <= DISP_DUPLICATE;
                     state_ff     <= S_DONE;
                  end else if (is_coll) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_disp_ff  <= DISP_COLLISION;
                     state_ff     <= S_DONE;
                  end else if (is_store) begin
                     rsp_valid_ff     <= 1'b1;
                     rsp_disp_ff      <= DISP_STORED;
                     mask_ff[seq_idx] <= 1'b1;
                     state_ff         <= S_DONE;
                  end else begin
                     // in-order packet: hold it until we know whether it is last
                     pend_ff  <= '{seq: seq_ff, handle: handle_ff, length: length_ff};
                     expw_ff  <= cmp_rsp.b_next;
                     state_ff <= S_DRAIN_RD;
                  end
               end
            end
            S_DRAIN_RD: begin
               if (mask_ff[exp_idx]) begin
                  state_ff <= S_DRAIN_CHK;
               end else if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_disp_ff  <= DISP_RELEASED;
                  rsp_entry_ff <= pend_ff;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= S_DONE;
               end
            end
            S_DRAIN_CHK: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_disp_ff  <= DISP_RELEASED;
                  rsp_entry_ff <= pend_ff;
                  if (cmp_rsp.eq) begin
                     rsp_last_ff      <= 1'b0;
                     pend_ff          <= ram_rd_data;
                     mask_ff[exp_idx] <= 1'b0;
                     expw_ff          <= cmp_rsp.b_next;
                     state_ff         <= S_DRAIN_RD;
                  end else begin
                     rsp_last_ff <= 1'b1;
                     state_ff    <= S_DONE;
                  end
               end
            end
            S_DONE: begin
               exp_mem_ff[sess_ff]   <= expw_ff;
               row_valid_ff[sess_ff] <= 1'b1;
               state_ff              <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_disposition = rsp_disp_ff;
   assign rsp_out_handle  = rsp_entry_ff.handle;
   assign rsp_out_length  = rsp_entry_ff.length;
   assign rsp_out_seq     = rsp_entry_ff.seq;
   assign rsp_last        = rsp_last_ff;

   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_LOAD)
      else $error("accepted transaction did not start lookup");

   a_chk_occupied: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DRAIN_CHK |-> mask_ff[exp_idx])
      else $error("drain check on an empty slot");

   a_store_marks: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> mask_ff[seq_idx] && state_ff == S_DONE)
      else $error("stored entry not marked occupied");

   a_done_row: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> row_valid_ff[sess_ff] && state_ff == S_IDLE)
      else $error("session row not committed");

endmodule

// ===== tb/reorder_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reorder_checker
// Watches both channels of the sequence reorder window, keeps its own copy
// of every session's expected number and slot window, and compares each
// returned result field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module reorder_checker import srw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_command,
   input  logic [SESS_W-1:0] req_session_slot,
   input  logic [SEQ_W-1:0]  req_seq_number,
   input  logic [SEQ_W-1:0]  req_payload_handle,
   input  logic [SEQ_W-1:0]  req_payload_length,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [DISP_W-1:0] rsp_disposition,
   input  logic [SEQ_W-1:0]  rsp_out_handle,
   input  logic [SEQ_W-1:0]  rsp_out_length,
   input  logic [SEQ_W-1:0]  rsp_out_seq,
   input  logic              rsp_last,
   output int                mismatch_count,
   output int                results_owed
);

   typedef struct packed {
      disp_type         disp;
      logic [SEQ_W-1:0] handle;
      logic [SEQ_W-1:0] length;
      logic [SEQ_W-1:0] seq;
      logic             last;
   } outcome_type;

   logic [SEQ_W-1:0] next_seq [SESSIONS];
   logic             slot_full [SLOTS];
   logic [SEQ_W-1:0] slot_seq [SLOTS];
   logic [SEQ_W-1:0] slot_handle [SLOTS];
   logic [SEQ_W-1:0] slot_len [SLOTS];

   outcome_type awaited_outcomes [$];
   outcome_type oldest;
   int          miss_tally = 0;

   initial begin
      for (int s = 0; s < SESSIONS; s++) next_seq[s] = '0;
      for (int i = 0; i < SLOTS; i++) slot_full[i] = 1'b0;
      mismatch_count = 0;
      results_owed   = 0;
   end

   task automatic owe(input disp_type d, input logic [SEQ_W-1:0] h,
                      input logic [SEQ_W-1:0] l, input logic [SEQ_W-1:0] s,
                      input logic last);
      outcome_type o;
      o.disp   = d;
      o.handle = h;
      o.length = l;
      o.seq    = s;
      o.last   = last;
      awaited_outcomes.push_back(o);
   endtask

   // Applies one accepted transaction to the shadow windows and queues the
   // results it must cause.
   task automatic window_update(input logic cmd, input logic [SESS_W-1:0] sess,
                                input logic [SEQ_W-1:0] seq,
                                input logic [SEQ_W-1:0] handle,
                                input logic [SEQ_W-1:0] length);
      int               base;
      int               idx;
      logic [SEQ_W-1:0] nxt;
      base = int'(sess) * WINDOW;
      if (cmd == CMD_CLEAR) begin
         next_seq[sess] = '0;
         for (int i = 0; i < WINDOW; i++) slot_full[base + i] = 1'b0;
         owe(DISP_CLEARED, '0, '0, '0, 1'b1);
      end else if (length == '0) begin
         owe(DISP_EMPTY, '0, '0, '0, 1'b1);
      end else if (seq < next_seq[sess]) begin
         owe(DISP_DUPLICATE, '0, '0, '0, 1'b1);
      end else if (seq > next_seq[sess]) begin
         idx = base + int'(seq) % WINDOW;
         if (slot_full[idx]) begin
            owe(DISP_COLLISION, '0, '0, '0, 1'b1);
         end else begin
            slot_full[idx]   = 1'b1;
            slot_seq[idx]    = seq;
            slot_handle[idx] = handle;
            slot_len[idx]    = length;
            owe(DISP_STORED, '0, '0, '0, 1'b1);
         end
      end else begin
         owe(DISP_RELEASED, handle, length, seq, 1'b0);
         nxt = seq + 1'b1;
         // drain stops at an empty slot or one holding a different lap
         for (int i = 0; i < WINDOW; i++) begin
            idx = base + int'(nxt) % WINDOW;
            if (!slot_full[idx] || slot_seq[idx] != nxt) break;
            owe(DISP_RELEASED, slot_handle[idx], slot_len[idx], slot_seq[idx], 1'b0);
            slot_full[idx] = 1'b0;
            nxt = nxt + 1'b1;
         end
         next_seq[sess] = nxt;
         awaited_outcomes[awaited_outcomes.size() - 1].last = 1'b1;
      end
   endtask

   task automatic compare_field(input string name, input logic [SEQ_W-1:0] want,
                                input logic [SEQ_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         miss_tally++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_outcomes.size() == 0) begin
               $error("unexpected result transaction: disposition %0d seq %0d",
                      rsp_disposition, rsp_out_seq);
               miss_tally++;
            end else begin
               oldest = awaited_outcomes.pop_front();
               compare_field("disposition", SEQ_W'(oldest.disp), SEQ_W'(rsp_disposition));
               compare_field("out_handle", oldest.handle, rsp_out_handle);
               compare_field("out_length", oldest.length, rsp_out_length);
               compare_field("out_seq", oldest.seq, rsp_out_seq);
               compare_field("last", SEQ_W'(oldest.last), SEQ_W'(rsp_last));
            end
         end
         if (req_valid && !req_stall)
            window_update(req_command, req_session_slot, req_seq_number,
                          req_payload_handle, req_payload_length);
      end
      mismatch_count <= miss_tally;
      results_owed   <= awaited_outcomes.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the sequence reorder window with directed cases and random reorder
// bursts with noise, under random idling on both channels. Checking is in
// reorder_checker.
// ----------------------------------------------------------------------------
module testbench;
   import srw_pkg::*;

   localparam int IDLE_LIMIT   = 1000;
   localparam int RANDOM_ITEMS = 80;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_command;
   logic [SESS_W-1:0] req_session_slot;
   logic [SEQ_W-1:0]  req_seq_number;
   logic [SEQ_W-1:0]  req_payload_handle;
   logic [SEQ_W-1:0]  req_payload_length;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [DISP_W-1:0] rsp_disposition;
   logic [SEQ_W-1:0]  rsp_out_handle;
   logic [SEQ_W-1:0]  rsp_out_length;
   logic [SEQ_W-1:0]  rsp_out_seq;
   logic              rsp_last;
   int                mismatch_count;
   int                results_owed;

   bit quiet = 1'b0;
   int stall_left = 0;
   int idle_cycles = 0;

   sequence_reorder_window DUT (.*);
   reorder_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_command        = CMD_DELIVER;
      req_session_slot   = '0;
      req_seq_number     = '0;
      req_payload_handle = '0;
      req_payload_length = '0;
      rsp_stall          = 1'b0;
   end

   // receiver backpressure: a fresh stall length per result transaction
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         stall_left = quiet ? 0 : $urandom_range(0, 11);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("sequence_reorder_window verification failed");
            $finish;
         end
      end
   end

   task automatic send(input logic cmd, input logic [SESS_W-1:0] sess,
                       input logic [SEQ_W-1:0] seq, input logic [SEQ_W-1:0] handle,
                       input logic [SEQ_W-1:0] length);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 11);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          = 1'b1;
      req_command        = cmd;
      req_session_slot   = sess;
      req_seq_number     = seq;
      req_payload_handle = handle;
      req_payload_length = length;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      int               sent;
      int               k;
      int               skip;
      int               j;
      int               tmp;
      int               order [64];
      logic [SESS_W-1:0] sess;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes and every disposition
      send(CMD_DELIVER, 4'd0, 16'd0, 16'hFFFF, 16'd0);       // empty
      send(CMD_DELIVER, 4'd0, 16'd0, 16'hFFFF, 16'hFFFF);    // released
      send(CMD_DELIVER, 4'd0, 16'd0, 16'h1234, 16'd5);       // duplicate
      send(CMD_DELIVER, 4'd0, 16'hFFFF, 16'd0, 16'd1);       // stored, top slot
      send(CMD_DELIVER, 4'd0, 16'd31, 16'h0F0F, 16'd9);      // collision
      send(CMD_DELIVER, 4'd0, 16'd3, 16'h0003, 16'd30);
      send(CMD_DELIVER, 4'd0, 16'd2, 16'h0002, 16'd20);
      send(CMD_DELIVER, 4'd0, 16'd1, 16'h0001, 16'd10);      // release plus drain
      send(CMD_CLEAR, 4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send(CMD_DELIVER, 4'd0, 16'hFFFF, 16'hBEEF, 16'd7);    // slot free again
      // stored entry from a later lap must stop the drain
      send(CMD_DELIVER, 4'd1, 16'd33, 16'h0033, 16'd33);
      send(CMD_DELIVER, 4'd1, 16'd0, 16'h0100, 16'd1);
      send(CMD_DELIVER, 4'd1, 16'd1, 16'h0101, 16'd2);
      send(CMD_CLEAR, 4'd15, 16'd0, 16'd0, 16'd0);
      send(CMD_DELIVER, 4'd15, 16'd0, 16'd0, 16'd1);

      // random reorder bursts, each starting from a cleared session
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 3) == 0);
         sess  = SESS_W'($urandom_range(0, SESSIONS - 1));
         send(CMD_CLEAR, sess, SEQ_W'($urandom()), SEQ_W'($urandom()),
              SEQ_W'($urandom()));
         sent++;
         k = ($urandom_range(0, 7) == 0) ? WINDOW + 1 : $urandom_range(1, 12);
         for (int i = 0; i < k; i++) order[i] = i;
         for (int i = k - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
         end
         if (k == WINDOW + 1) begin
            // hold the in-order packet back so the whole window drains at once
            for (int i = 0; i < k; i++)
               if (order[i] == 0) begin
                  order[i]     = order[k - 1];
                  order[k - 1] = 0;
               end
         end
         skip = ($urandom_range(0, 5) == 0) ? $urandom_range(0, k - 1) : -1;
         for (int i = 0; i < k; i++) begin
            if (i != skip) begin
               send(CMD_DELIVER, sess, SEQ_W'(order[i]), SEQ_W'($urandom()),
                    SEQ_W'($urandom_range(1, 65535)));
               sent++;
            end
            if ($urandom_range(0, 7) == 0) begin
               case ($urandom_range(0, 3))
                  0: send(CMD_DELIVER, sess, SEQ_W'(order[$urandom_range(0, i)]),
                          SEQ_W'($urandom()), SEQ_W'($urandom_range(1, 65535)));
                  1: send(CMD_DELIVER, sess, SEQ_W'($urandom()), SEQ_W'($urandom()),
                          16'd0);
                  2: send(1'($urandom_range(0, 1)),
                          sess + SESS_W'($urandom_range(1, 15)),
                          SEQ_W'($urandom()), SEQ_W'($urandom()), SEQ_W'($urandom()));
                  default: send(CMD_DELIVER, sess, SEQ_W'($urandom()),
                                SEQ_W'($urandom()), SEQ_W'($urandom_range(1, 65535)));
               endcase
               sent++;
            end
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      wait (results_owed == 0);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("sequence_reorder_window verification clean");
      else
         $display("sequence_reorder_window verification failed");
      $finish;
   end

endmodule
